/* rtl/mva_pkg.sv */
// Shared constants for the mesh volume accumulator.
`default_nettype none
package mva_pkg;
	localparam int ACC_BITS = 64;              // running sum width, signed
	localparam int VOL_BITS = ACC_BITS - 1;    // volume result width
	localparam int DIV_BITS_PER_CYCLE = 8;     // quotient bits per divide cycle
	localparam int DIV_CYCLES = ACC_BITS / DIV_BITS_PER_CYCLE;
	localparam int QUEUE_DEPTH = 4;            // power of two
	localparam int DIV_DIVISOR = 3;            // |sum|/6 done as (|sum|>>1)/3
endpackage
`default_nettype wire

/* rtl/mesh_volume_accumulator.sv */
// Top level of the mesh volume accumulator.
// Throughput: one triangle per cycle while the queue is not full; a mesh end
//   occupies the divider, so a following mesh end waits until it is idle.
// A last triangle's result passes, after the edge that accepts it, through 4
//   more product stages, queue write, divider load, the divide steps and the
//   result register.
// Reset: arst_n clears the sum, overflow flag, pipe, queue and result valid
//   flag; the block takes transactions as soon as reset is released.
`default_nettype none
module mesh_volume_accumulator #(
	parameter int COORD_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] az,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by_coord,
	input  wire logic signed [COORD_BITS-1:0] bz,
	input  wire logic signed [COORD_BITS-1:0] cx,
	input  wire logic signed [COORD_BITS-1:0] cy,
	input  wire logic signed [COORD_BITS-1:0] cz,
	input  wire                              last_triangle,
	input  wire                              push,
	output logic                             full,
	output logic [mva_pkg::VOL_BITS-1:0]     volume,
	output logic                             overflowed,
	output logic                             empty,
	input  wire                              pop
);
	import mva_pkg::*;

	// triple product width: three 3*C+1 bit terms summed
	localparam int TW = 3 * COORD_BITS + 3;

	logic                 f_push;
	logic signed [TW-1:0] f_prod;
	logic                 f_last;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_pop;
	logic [TW:0]          q_rdata;

	// front: takes each triangle transaction and forms a.(b x c)
	mva_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.ax            (ax),
		.ay            (ay),
		.az            (az),
		.bx            (bx),
		.by_coord      (by_coord),
		.bz            (bz),
		.cx            (cx),
		.cy            (cy),
		.cz            (cz),
		.last_triangle (last_triangle),
		.push          (push),
		.full          (full),
		.q_push        (f_push),
		.q_prod        (f_prod),
		.q_last        (f_last),
		.q_full        (q_full)
	);

	// decoupling queue: the front keeps streaming while the divider runs
	mva_queue #(.WIDTH(TW + 1), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (f_push),
		.wdata  ({f_last, f_prod}),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// back: saturating sum, |sum|/6 on mesh end, result register
	mva_back #(.TW(TW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_prod     ($signed(q_rdata[TW-1:0])),
		.q_last     (q_rdata[TW]),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.volume     (volume),
		.overflowed (overflowed),
		.empty      (empty),
		.pop        (pop)
	);
endmodule
`default_nettype wire

/* rtl/mva_front.sv */
// Front end: accepts triangles and computes the triple product in a pipeline.
`default_nettype none
module mva_front #(
	parameter int COORD_BITS = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] az,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by_coord,
	input  wire logic signed [COORD_BITS-1:0] bz,
	input  wire logic signed [COORD_BITS-1:0] cx,
	input  wire logic signed [COORD_BITS-1:0] cy,
	input  wire logic signed [COORD_BITS-1:0] cz,
	input  wire                              last_triangle,
	input  wire                              push,
	output logic                             full,
	output logic                             q_push,
	output logic signed [3*COORD_BITS+2:0]   q_prod,
	output logic                             q_last,
	input  wire                              q_full
);
	localparam int C  = COORD_BITS;
	localparam int PW = 2 * C;
	localparam int DW = 2 * C + 1;
	localparam int MW = 3 * C + 1;
	localparam int TW = 3 * C + 3;

	logic adv;
	logic accept;
	logic load_s1;

	// stage 1: captured vertices
	logic                v_s1, last_s1;
	logic signed [C-1:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1, cx_s1, cy_s1, cz_s1;
	// stage 2: pairwise products of b and c
	logic                v_s2, last_s2;
	logic signed [C-1:0] ax_s2, ay_s2, az_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	// stage 3: cross product components
	logic                v_s3, last_s3;
	logic signed [C-1:0] ax_s3, ay_s3, az_s3;
	logic signed [DW-1:0] d0_s3, d1_s3, d2_s3;
	// stage 4: dot product terms
	logic                v_s4, last_s4;
	logic signed [MW-1:0] m0_s4, m1_s4, m2_s4;
	// stage 5: triple product
	logic                v_s5, last_s5;
	logic signed [TW-1:0] t_s5;

	// stages 2-5 move together, stage 1 also fills while empty; only a full queue stops them
	assign adv     = !(v_s5 && q_full);
	assign load_s1 = adv || !v_s1;
	assign full    = !load_s1;
	assign accept  = push && load_s1;

	assign q_push = v_s5 && adv;
	assign q_prod = t_s5;
	assign q_last = last_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1 <= accept;
			end
			if (adv) begin
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			ax_s1   <= ax;
			ay_s1   <= ay;
			az_s1   <= az;
			bx_s1   <= bx;
			by_s1   <= by_coord;
			bz_s1   <= bz;
			cx_s1   <= cx;
			cy_s1   <= cy;
			cz_s1   <= cz;
			last_s1 <= last_triangle;
		end
		if (adv) begin
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			az_s2   <= az_s1;
			p0_s2   <= by_s1 * cz_s1;
			p1_s2   <= bz_s1 * cy_s1;
			p2_s2   <= bz_s1 * cx_s1;
			p3_s2   <= bx_s1 * cz_s1;
			p4_s2   <= bx_s1 * cy_s1;
			p5_s2   <= by_s1 * cx_s1;
			last_s2 <= last_s1;

			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
			az_s3   <= az_s2;
			d0_s3   <= $signed({p0_s2[PW-1], p0_s2}) - $signed({p1_s2[PW-1], p1_s2});
			d1_s3   <= $signed({p2_s2[PW-1], p2_s2}) - $signed({p3_s2[PW-1], p3_s2});
			d2_s3   <= $signed({p4_s2[PW-1], p4_s2}) - $signed({p5_s2[PW-1], p5_s2});
			last_s3 <= last_s2;

			m0_s4   <= ax_s3 * d0_s3;
			m1_s4   <= ay_s3 * d1_s3;
			m2_s4   <= az_s3 * d2_s3;
			last_s4 <= last_s3;

			t_s5    <= $signed({{2{m0_s4[MW-1]}}, m0_s4})
			         + $signed({{2{m1_s4[MW-1]}}, m1_s4})
			         + $signed({{2{m2_s4[MW-1]}}, m2_s4});
			last_s5 <= last_s4;
		end
	end
endmodule
`default_nettype wire

/* rtl/mva_queue.sv */
// Small FIFO between the product pipeline and the accumulator.
`default_nettype none
module mva_queue #(
	parameter int WIDTH = 52,
	parameter int DEPTH = 4
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr,
	input  wire [WIDTH-1:0]  wdata,
	output logic             full,
	input  wire              rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wptr_q] <= wdata;
		end
	end
endmodule
`default_nettype wire

/* rtl/mva_back.sv */
// Back end: saturating accumulator, divide by six and result register.
`default_nettype none
module mva_back #(
	parameter int TW = 51
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire logic signed [TW-1:0]    q_prod,
	input  wire                          q_last,
	input  wire                          q_empty,
	output logic                         q_pop,
	output logic [mva_pkg::VOL_BITS-1:0] volume,
	output logic                         overflowed,
	output logic                         empty,
	input  wire                          pop
);
	import mva_pkg::*;

	localparam int SW = ACC_BITS + 1;
	localparam int NW = $clog2(DIV_CYCLES);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic signed [ACC_BITS-1:0] SUM_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] SUM_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	logic signed [ACC_BITS-1:0] acc_q;
	logic                       sat_q;
	logic [1:0]                 state_q;
	logic [NW-1:0]              step_q;
	logic [ACC_BITS-1:0]        div_q;
	logic [1:0]                 rem_q;
	logic                       div_ovf_q;
	logic                       out_valid_q;
	logic [VOL_BITS-1:0]        vol_q;
	logic                       ovf_q;

	logic signed [SW-1:0]       wide_sum;
	logic                       add_ovf;
	logic signed [ACC_BITS-1:0] new_sum;
	logic [ACC_BITS-1:0]        mag;
	logic [DIV_BITS_PER_CYCLE-1:0] qbits;
	logic [1:0]                 rem_next;
	logic                       hand_off;

	assign wide_sum = $signed({acc_q[ACC_BITS-1], acc_q})
	                + $signed({{(SW-TW){q_prod[TW-1]}}, q_prod});
	assign add_ovf  = wide_sum[SW-1] != wide_sum[SW-2];
	assign new_sum  = !add_ovf ? wide_sum[ACC_BITS-1:0] :
	                  (wide_sum[SW-1] ? SUM_MIN : SUM_MAX);
	assign mag      = new_sum[ACC_BITS-1] ? (~new_sum + 1'b1) : new_sum;

	// a mesh end waits while the divider is occupied
	assign q_pop    = !q_empty && (!q_last || state_q == ST_IDLE);
	assign hand_off = (state_q == ST_DONE) && (!out_valid_q || pop);

	// long division by three, MSB first, a byte of quotient per cycle
	always_comb begin
		logic [2:0] r;
		r = {1'b0, rem_q};
		for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
			r = {r[1:0], div_q[ACC_BITS-1-i]};
			qbits[DIV_BITS_PER_CYCLE-1-i] = (r >= 3'(DIV_DIVISOR));
			if (r >= 3'(DIV_DIVISOR)) begin
				r = r - 3'(DIV_DIVISOR);
			end
		end
		rem_next = r[1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			sat_q       <= 1'b0;
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_last) begin
					acc_q <= '0;
					sat_q <= 1'b0;
				end else begin
					acc_q <= new_sum;
					sat_q <= sat_q || add_ovf;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_last) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == NW'(DIV_CYCLES - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (hand_off) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (hand_off) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop && q_last) begin
			div_q     <= {1'b0, mag[ACC_BITS-1:1]};
			rem_q     <= '0;
			div_ovf_q <= sat_q || add_ovf;
		end else if (state_q == ST_RUN) begin
			div_q <= {div_q[ACC_BITS-DIV_BITS_PER_CYCLE-1:0], qbits};
			rem_q <= rem_next;
		end
		if (hand_off) begin
			vol_q <= div_q[VOL_BITS-1:0];
			ovf_q <= div_ovf_q;
		end
	end

	assign volume     = vol_q;
	assign overflowed = ovf_q;
	assign empty      = !out_valid_q;
endmodule
`default_nettype wire
